// ===== rtl/core/shs_pkg.sv =====
// ============================================================================
// shs_pkg
// Shared types, constants and round functions for the SHA-256 stream hasher.
// ============================================================================
package shs_pkg;

    localparam int unsigned WORD_W     = 32;
    localparam int unsigned ROUNDS     = 64;
    localparam int unsigned BLOCK_WDS  = 16;
    localparam int unsigned HASH_WDS   = 8;

    localparam logic [7:0]  MARK_BYTE     = 8'h80;
    localparam logic [5:0]  LAST_BYTE_POS = 6'd63;
    localparam logic [5:0]  LEN_BYTE_POS  = 6'd56;
    localparam logic [5:0]  LAST_ROUND    = 6'd63;
    localparam logic [2:0]  LAST_WORD_IDX = 3'd7;
    localparam logic [63:0] BITS_PER_BYTE = 64'd8;

    localparam logic [31:0] INIT_HASH [HASH_WDS] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_message;
    } shs_msg_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } shs_digest_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FOLD,
        ST_PAD_MARK,
        ST_PAD_ZERO,
        ST_PAD_LEN,
        ST_EMIT
    } shs_state_t;

    typedef enum logic [1:0] {
        SEL_DATA,
        SEL_MARK,
        SEL_ZERO,
        SEL_LEN
    } shs_byte_sel_t;

    typedef struct packed {
        logic          put_byte;
        shs_byte_sel_t byte_sel;
        logic          count_bits;
        logic          load_work;
        logic          round_en;
        logic [5:0]    round_idx;
        logic          fold;
        logic          restart;
        logic [2:0]    word_idx;
    } shs_cmd_t;

    typedef struct packed {
        logic [5:0] byte_pos;
    } shs_status_t;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (WORD_W - n));
    endfunction

    function automatic logic [31:0] bsig0(input logic [31:0] x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] bsig1(input logic [31:0] x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] ssig0(input logic [31:0] x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] ssig1(input logic [31:0] x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

// ===== rtl/core/shs_ctrl.sv =====
// ============================================================================
// shs_ctrl
// Sequencer: byte intake, padding, round counting and digest readout.
// ============================================================================
module shs_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 msg_valid,
    output logic                 msg_stall,
    input  shs_pkg::shs_msg_t    msg,
    output logic                 dig_valid,
    input  logic                 dig_stall,
    output shs_pkg::shs_cmd_t    cmd,
    input  shs_pkg::shs_status_t status
);

    shs_pkg::shs_state_t state_reg, state_next;
    shs_pkg::shs_state_t resume_reg, resume_next;
    logic [5:0] round_reg, round_next;
    logic [2:0] word_reg, word_next;
    logic       block_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= shs_pkg::ST_IDLE;
            resume_reg <= shs_pkg::ST_IDLE;
            round_reg  <= '0;
            word_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            resume_reg <= resume_next;
            round_reg  <= round_next;
            word_reg   <= word_next;
        end
    end

    assign block_full = (status.byte_pos == shs_pkg::LAST_BYTE_POS);

    always_comb
    begin
        state_next    = state_reg;
        resume_next   = resume_reg;
        round_next    = round_reg;
        word_next     = word_reg;
        msg_stall     = 1'b1;
        dig_valid     = 1'b0;
        cmd           = '0;
        cmd.byte_sel  = shs_pkg::SEL_DATA;
        cmd.round_idx = round_reg;
        cmd.word_idx  = word_reg;

        case (state_reg)
            shs_pkg::ST_IDLE:
            begin
                msg_stall = 1'b0;
                if (msg_valid)
                begin
                    if (msg.byte_present)
                    begin
                        cmd.put_byte   = 1'b1;
                        cmd.count_bits = 1'b1;
                    end
                    if (msg.byte_present && block_full)
                    begin
                        cmd.load_work = 1'b1;
                        round_next    = '0;
                        state_next    = shs_pkg::ST_ROUND;
                        resume_next   = msg.end_of_message ? shs_pkg::ST_PAD_MARK
                                                           : shs_pkg::ST_IDLE;
                    end
                    else if (msg.end_of_message)
                    begin
                        state_next = shs_pkg::ST_PAD_MARK;
                    end
                end
            end
            shs_pkg::ST_PAD_MARK:
            begin
                cmd.put_byte = 1'b1;
                cmd.byte_sel = shs_pkg::SEL_MARK;
                if (block_full)
                begin
                    cmd.load_work = 1'b1;
                    round_next    = '0;
                    state_next    = shs_pkg::ST_ROUND;
                    resume_next   = shs_pkg::ST_PAD_ZERO;
                end
                else
                begin
                    state_next = shs_pkg::ST_PAD_ZERO;
                end
            end
            shs_pkg::ST_PAD_ZERO:
            begin
                if (status.byte_pos == shs_pkg::LEN_BYTE_POS)
                begin
                    state_next = shs_pkg::ST_PAD_LEN;
                end
                else
                begin
                    cmd.put_byte = 1'b1;
                    cmd.byte_sel = shs_pkg::SEL_ZERO;
                    if (block_full)
                    begin
                        cmd.load_work = 1'b1;
                        round_next    = '0;
                        state_next    = shs_pkg::ST_ROUND;
                        resume_next   = shs_pkg::ST_PAD_ZERO;
                    end
                end
            end
            shs_pkg::ST_PAD_LEN:
            begin
                cmd.put_byte = 1'b1;
                cmd.byte_sel = shs_pkg::SEL_LEN;
                if (block_full)
                begin
                    cmd.load_work = 1'b1;
                    round_next    = '0;
                    state_next    = shs_pkg::ST_ROUND;
                    resume_next   = shs_pkg::ST_EMIT;
                end
            end
            shs_pkg::ST_ROUND:
            begin
                cmd.round_en = 1'b1;
                round_next   = round_reg + 6'd1;
                if (round_reg == shs_pkg::LAST_ROUND)
                begin
                    state_next = shs_pkg::ST_FOLD;
                end
            end
            shs_pkg::ST_FOLD:
            begin
                cmd.fold   = 1'b1;
                word_next  = '0;
                state_next = resume_reg;
            end
            shs_pkg::ST_EMIT:
            begin
                dig_valid = 1'b1;
                if (!dig_stall)
                begin
                    if (word_reg == shs_pkg::LAST_WORD_IDX)
                    begin
                        cmd.restart = 1'b1;
                        state_next  = shs_pkg::ST_IDLE;
                    end
                    else
                    begin
                        word_next = word_reg + 3'd1;
                    end
                end
            end
            default:
            begin
                state_next = shs_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/shs_datapath.sv =====
// ============================================================================
// shs_datapath
// Block buffer / schedule shifter, round registers, hash state, bit count.
// ============================================================================
module shs_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [7:0]           data_byte,
    input  shs_pkg::shs_cmd_t    cmd,
    output shs_pkg::shs_status_t status,
    output shs_pkg::shs_digest_t dig
);

    logic [31:0] hash_reg  [shs_pkg::HASH_WDS];
    logic [31:0] work_reg  [shs_pkg::HASH_WDS];
    logic [31:0] block_reg [shs_pkg::BLOCK_WDS];
    logic [63:0] bit_count_reg;
    logic [5:0]  pos_reg;

    logic [7:0]  byte_val;
    logic [3:0]  word_sel;
    logic [1:0]  lane;
    logic [31:0] w_new;
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] ch;
    logic [31:0] maj;

    // Length bytes go out big-endian: pos 56 carries bits 63:56.
    always_comb
    begin
        case (cmd.byte_sel)
            shs_pkg::SEL_DATA: byte_val = data_byte;
            shs_pkg::SEL_MARK: byte_val = shs_pkg::MARK_BYTE;
            shs_pkg::SEL_ZERO: byte_val = 8'h00;
            shs_pkg::SEL_LEN:  byte_val = bit_count_reg[{~pos_reg[2:0], 3'b000} +: 8];
            default:           byte_val = 8'h00;
        endcase
    end

    assign word_sel = pos_reg[5:2];
    assign lane     = pos_reg[1:0];

    assign w_new = shs_pkg::ssig1(block_reg[14]) + block_reg[9]
                 + shs_pkg::ssig0(block_reg[1]) + block_reg[0];

    assign ch  = (work_reg[4] & work_reg[5]) ^ (~work_reg[4] & work_reg[6]);
    assign maj = (work_reg[0] & work_reg[1]) ^ (work_reg[0] & work_reg[2])
               ^ (work_reg[1] & work_reg[2]);
    assign t1  = work_reg[7] + shs_pkg::bsig1(work_reg[4]) + ch
               + shs_pkg::ROUND_K[cmd.round_idx] + block_reg[0];
    assign t2  = shs_pkg::bsig0(work_reg[0]) + maj;

    // Block buffer doubles as the 16-deep schedule window during rounds.
    // First byte of a word clears the rest, so no clear pass is needed.
    always_ff @(posedge clk)
    begin
        if (cmd.round_en)
        begin
            for (int i = 0; i < shs_pkg::BLOCK_WDS - 1; i++)
            begin
                block_reg[i] <= block_reg[i + 1];
            end
            block_reg[shs_pkg::BLOCK_WDS - 1] <= w_new;
        end
        else if (cmd.put_byte)
        begin
            if (lane == 2'd0)
            begin
                block_reg[word_sel] <= {byte_val, 24'h000000};
            end
            else
            begin
                block_reg[word_sel][{~lane, 3'b000} +: 8] <= byte_val;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_work)
        begin
            for (int i = 0; i < shs_pkg::HASH_WDS; i++)
            begin
                work_reg[i] <= hash_reg[i];
            end
        end
        else if (cmd.round_en)
        begin
            work_reg[7] <= work_reg[6];
            work_reg[6] <= work_reg[5];
            work_reg[5] <= work_reg[4];
            work_reg[4] <= work_reg[3] + t1;
            work_reg[3] <= work_reg[2];
            work_reg[2] <= work_reg[1];
            work_reg[1] <= work_reg[0];
            work_reg[0] <= t1 + t2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < shs_pkg::HASH_WDS; i++)
            begin
                hash_reg[i] <= shs_pkg::INIT_HASH[i];
            end
            bit_count_reg <= '0;
            pos_reg       <= '0;
        end
        else
        begin
            if (cmd.restart)
            begin
                for (int i = 0; i < shs_pkg::HASH_WDS; i++)
                begin
                    hash_reg[i] <= shs_pkg::INIT_HASH[i];
                end
            end
            else if (cmd.fold)
            begin
                for (int i = 0; i < shs_pkg::HASH_WDS; i++)
                begin
                    hash_reg[i] <= hash_reg[i] + work_reg[i];
                end
            end

            if (cmd.restart)
            begin
                bit_count_reg <= '0;
                pos_reg       <= '0;
            end
            else
            begin
                if (cmd.count_bits)
                begin
                    bit_count_reg <= bit_count_reg + shs_pkg::BITS_PER_BYTE;
                end
                if (cmd.put_byte)
                begin
                    pos_reg <= pos_reg + 6'd1;
                end
            end
        end
    end

    assign status.byte_pos = pos_reg;

    assign dig.digest_word = hash_reg[cmd.word_idx];
    assign dig.word_index  = cmd.word_idx;
    assign dig.last_word   = (cmd.word_idx == shs_pkg::LAST_WORD_IDX);

endmodule

// ===== rtl/core/sha256_stream_hasher_core.sv =====
// ============================================================================
// sha256_stream_hasher_core
// SHA-256 over a byte stream; emits the digest as eight 32-bit words.
// ============================================================================
//
//  channel | dir | payload       | request
//  --------+-----+---------------+------------------------------------------
//  msg     | in  | shs_msg_t     | one message byte and/or end-of-message
//  dig     | out | shs_digest_t  | one digest word, word 0 first, 8 per msg
//
//  A byte request is taken in the idle state. The request that fills a block
//  then runs 64 rounds at one per cycle in the shared round unit, and then a
//  fold of the working variables into the hash.
//  End of message: padding bytes one per cycle (up to 64 + 8), an empty step
//  at byte 56, rounds and fold per extra block, then 8 digest words, one per
//  accepted cycle on dig. msg is stalled from finish until the last word goes.
//  Reset loads the initial hash and clears count and byte position; no sweep.
//
module sha256_stream_hasher_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 msg_valid,
    output logic                 msg_stall,
    input  shs_pkg::shs_msg_t    msg,
    output logic                 dig_valid,
    input  logic                 dig_stall,
    output shs_pkg::shs_digest_t dig
);

    shs_pkg::shs_cmd_t    cmd;
    shs_pkg::shs_status_t status;

    // Sequencer: decides which byte goes in, when rounds run, readout.
    shs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .msg_valid (msg_valid),
        .msg_stall (msg_stall),
        .msg       (msg),
        .dig_valid (dig_valid),
        .dig_stall (dig_stall),
        .cmd       (cmd),
        .status    (status)
    );

    // Datapath: block buffer, one round per cycle, hash and length state.
    shs_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .data_byte (msg.data_byte),
        .cmd       (cmd),
        .status    (status),
        .dig       (dig)
    );

    // No new message byte while a digest is being read out.
    a_no_intake_during_emit: assert property (
        @(posedge clk) disable iff (!rst_n)
        dig_valid |-> msg_stall
    ) else $error("msg request open while digest pending");

    // The working variables load only together with the write of the block's last byte.
    a_load_on_full_block: assert property (
        @(posedge clk) disable iff (!rst_n)
        cmd.load_work |-> (cmd.put_byte && status.byte_pos == shs_pkg::LAST_BYTE_POS)
    ) else $error("round load without a full block");

    // Digest words go out in order.
    a_word_order: assert property (
        @(posedge clk) disable iff (!rst_n)
        (dig_valid && !dig_stall && !dig.last_word)
            |=> (dig.word_index == $past(dig.word_index) + 3'd1)
    ) else $error("digest word out of order");

    // After the last word the block is back at the start of a message.
    a_restart_after_digest: assert property (
        @(posedge clk) disable iff (!rst_n)
        (dig_valid && !dig_stall && dig.last_word)
            |=> (status.byte_pos == 6'd0 && !dig_valid && !msg_stall)
    ) else $error("no clean restart after digest");

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Checks sha256_stream_hasher_core against its own SHA-256 predictor. Byte
// requests come in random bursts. The digest side stalls in changing patterns.
// Every digest word is compared field by field with the predicted word.
// ============================================================================
module testbench;

    localparam int          MSG_ITEMS    = 310;
    localparam int          CYCLE_LIMIT  = 600000;
    localparam int          DRAIN_CYCLES = 100;
    localparam logic [7:0]  PAD_MARK     = 8'h80;
    localparam logic [5:0]  LEN_SLOT     = 6'd56;
    localparam logic [2:0]  FINAL_IDX    = 3'd7;

    localparam logic [31:0] IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] K_TAB [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // Running SHA-256 state plus the digest words still owed by the core.
    class digest_tracker;
        logic [31:0] hash_state [8];
        logic [31:0] block_buf [16];
        logic [63:0] msg_bits;
        logic [5:0]  fill_pos;
        shs_pkg::shs_digest_t pending_words [$];
        int unsigned mismatches;

        function new();
            mismatches = 0;
            restart();
        endfunction

        function void restart();
            for (int i = 0; i < 8; i++)
                hash_state[i] = IV[i];
            for (int i = 0; i < 16; i++)
                block_buf[i] = '0;
            msg_bits = '0;
            fill_pos = '0;
        endfunction

        function logic [31:0] ror(input logic [31:0] x, input int n);
            return (x >> n) | (x << (32 - n));
        endfunction

        function void compress();
            logic [31:0] w [64];
            logic [31:0] v [8];
            logic [31:0] s0;
            logic [31:0] s1;
            logic [31:0] t1;
            logic [31:0] t2;
            for (int i = 0; i < 16; i++)
                w[i] = block_buf[i];
            for (int i = 16; i < 64; i++)
            begin
                s0 = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
                s1 = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
                w[i] = s1 + w[i-7] + s0 + w[i-16];
            end
            for (int i = 0; i < 8; i++)
                v[i] = hash_state[i];
            for (int i = 0; i < 64; i++)
            begin
                t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
                   + ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_TAB[i] + w[i];
                t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
                   + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
                v[7] = v[6];
                v[6] = v[5];
                v[5] = v[4];
                v[4] = v[3] + t1;
                v[3] = v[2];
                v[2] = v[1];
                v[1] = v[0];
                v[0] = t1 + t2;
            end
            for (int i = 0; i < 8; i++)
                hash_state[i] += v[i];
        endfunction

        // Big-endian byte placement; a fresh word starts cleared.
        function void load_byte(input logic [7:0] b);
            logic [31:0] lane;
            lane = {24'h0, b} << (8 * (3 - fill_pos[1:0]));
            if (fill_pos[1:0] == 2'd0)
                block_buf[fill_pos[5:2]] = lane;
            else
                block_buf[fill_pos[5:2]] |= lane;
            fill_pos += 6'd1;
            if (fill_pos == 6'd0)
                compress();
        endfunction

        function void absorb_request(input shs_pkg::shs_msg_t m);
            logic [63:0] length;
            shs_pkg::shs_digest_t d;
            if (m.byte_present)
            begin
                load_byte(m.data_byte);
                msg_bits += 64'd8;
            end
            if (!m.end_of_message)
                return;
            length = msg_bits;
            load_byte(PAD_MARK);
            while (fill_pos != LEN_SLOT)
                load_byte(8'h00);
            for (int i = 0; i < 8; i++)
                load_byte(length[63 - 8*i -: 8]);
            for (int i = 0; i < 8; i++)
            begin
                d.digest_word = hash_state[i];
                d.word_index  = 3'(i);
                d.last_word   = (3'(i) == FINAL_IDX);
                pending_words.push_back(d);
            end
            restart();
        endfunction

        function void check_word(input shs_pkg::shs_digest_t got);
            shs_pkg::shs_digest_t want;
            if (pending_words.size() == 0)
            begin
                $display("%0t: unexpected digest word, expected none, actual %h",
                         $time, got);
                mismatches++;
                return;
            end
            want = pending_words.pop_front();
            if (got.digest_word !== want.digest_word)
            begin
                $display("%0t: digest_word expected %h actual %h",
                         $time, want.digest_word, got.digest_word);
                mismatches++;
            end
            if (got.word_index !== want.word_index)
            begin
                $display("%0t: word_index expected %0d actual %0d",
                         $time, want.word_index, got.word_index);
                mismatches++;
            end
            if (got.last_word !== want.last_word)
            begin
                $display("%0t: last_word expected %b actual %b",
                         $time, want.last_word, got.last_word);
                mismatches++;
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n      = 1'b0;
    logic                 msg_valid  = 1'b0;
    logic                 msg_stall;
    shs_pkg::shs_msg_t    msg        = '0;
    logic                 dig_valid;
    logic                 dig_stall  = 1'b0;
    shs_pkg::shs_digest_t dig;

    digest_tracker tracker = new();

    int          burst_left  = 0;
    int          item_count  = 0;
    int          cycle_count = 0;
    logic [1:0]  stall_mode  = 2'd0;
    int          mode_left   = 0;

    sha256_stream_hasher_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .msg_valid (msg_valid),
        .msg_stall (msg_stall),
        .msg       (msg),
        .dig_valid (dig_valid),
        .dig_stall (dig_stall),
        .dig       (dig)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Digest side: check accepted words, stall in phases of changing style.
    always @(posedge clk)
    begin
        if (rst_n && dig_valid && !dig_stall)
            tracker.check_word(dig);
        if (mode_left == 0)
        begin
            stall_mode <= 2'($urandom_range(0, 3));
            mode_left  <= $urandom_range(20, 200);
        end
        else
            mode_left <= mode_left - 1;
        case (stall_mode)
            2'd0: dig_stall <= 1'b0;
            2'd1: dig_stall <= ($urandom_range(0, 3) == 0);
            2'd2: dig_stall <= ($urandom_range(0, 3) != 0);
            default: dig_stall <= cycle_count[1];
        endcase
    end

    // One request on msg; held until accepted, then maybe a gap.
    task automatic send_request(input logic [7:0] b, input logic present,
                                input logic fin);
        shs_pkg::shs_msg_t m;
        m.data_byte      = b;
        m.byte_present   = present;
        m.end_of_message = fin;
        msg_valid <= 1'b1;
        msg       <= m;
        do
            @(posedge clk);
        while (msg_stall);
        tracker.absorb_request(m);
        if (present || fin)
            item_count++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            msg_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            // Now and then a long burst with no gaps at all.
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(0, 10);
        end
    endtask

    // A message of len bytes, finished on the last byte or by an empty finish.
    task automatic send_message(input int len, input bit empty_finish);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 19) == 0)
                send_request(8'($urandom), 1'b0, 1'b0);
            send_request(8'($urandom), 1'b1, (i == len - 1) && !empty_finish);
        end
        if (len == 0 || empty_finish)
            send_request(8'($urandom), 1'b0, 1'b1);
    endtask

    initial
    begin
        int len;
        int start_items;
        int edges [7];
        edges = '{54, 55, 56, 57, 63, 64, 65};
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty message, ignored requests, byte extremes, "abc".
        send_request(8'h00, 1'b0, 1'b1);
        send_request(8'hff, 1'b0, 1'b0);
        send_request(8'hff, 1'b1, 1'b1);
        send_request(8'h00, 1'b1, 1'b0);
        send_request(8'hff, 1'b0, 1'b1);
        send_request(8'h61, 1'b1, 1'b0);
        send_request(8'h62, 1'b1, 1'b0);
        send_request(8'h63, 1'b1, 1'b1);
        send_request(8'h61, 1'b1, 1'b0);
        send_request(8'h00, 1'b0, 1'b0);
        send_request(8'h62, 1'b1, 1'b0);
        send_request(8'h5a, 1'b0, 1'b1);

        // Random messages, weighted toward short ones and block edges.
        start_items = item_count;
        while (item_count - start_items < MSG_ITEMS)
        begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3:     len = edges[$urandom_range(0, 6)];
                4, 5:           len = $urandom_range(11, 130);
                default:        len = $urandom_range(0, 10);
            endcase
            send_message(len, $urandom_range(0, 2) == 0);
        end

        msg_valid <= 1'b0;
        while (tracker.pending_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tracker.mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/shs_pkg.sv
rtl/core/shs_ctrl.sv
rtl/core/shs_datapath.sv
rtl/core/sha256_stream_hasher_core.sv
tb/sv/testbench.sv
